### design/lad_pkg.sv
// ----------------------------------------------------------------------------
// Lamp array cache package
// Shared beat types, operation codes, register indexes and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lad_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd3;

  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_FILL     = 3'd1;
  localparam logic [2:0] OP_MODE     = 3'd2;
  localparam logic [2:0] OP_ATTR_REQ = 3'd3;
  localparam logic [2:0] OP_ATTR_RD  = 3'd4;
  localparam logic [2:0] OP_COL_RD   = 3'd5;

  // Default effect colour after reset, packed gain/blue/green/red.
  localparam logic [31:0] DEFAULT_COLOUR_RESET = {8'd0, 8'd128, 8'd128, 8'd128};

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] lamp_id;
    logic [15:0] range_end;
    logic        write_enable;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  gain;
    logic        commit;
    logic        autonomous;
  } in_item_t;

  typedef struct packed {
    logic [15:0] attr_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_gain;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_FILL,
    CMD_MODE,
    CMD_ATTR_REQ,
    CMD_ATTR_RD,
    CMD_COL_RD,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [15:0] lamp_id;
    logic [15:0] range_end;
    logic [31:0] colour;
    logic        wen;
    logic        commit;
    logic        autonomous;
    logic        id_ok;
    logic        fill_ok;
  } cmd_t;

  function automatic logic [31:0] pack_colour(input in_item_t item);
    return {item.gain, item.blue, item.green, item.red};
  endfunction

endpackage

`default_nettype wire

### design/lad_ram.sv
// ----------------------------------------------------------------------------
// Lamp array cache RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/lad_front.sv
// ----------------------------------------------------------------------------
// Lamp array cache front end
// Accepts input beats, decodes and range-checks them, and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_front import lad_pkg::*; #(
  parameter int NUM_LAMPS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  input  wire logic     hold_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_ready_i
);

  localparam logic [15:0] LampLimit = 16'(NUM_LAMPS);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_d;
  logic       accept;
  logic       take;

  always_comb begin
    cmd_d            = '0;
    cmd_d.lamp_id    = item_i.lamp_id;
    cmd_d.range_end  = item_i.range_end;
    cmd_d.colour     = pack_colour(item_i);
    cmd_d.wen        = item_i.write_enable;
    cmd_d.commit     = item_i.commit;
    cmd_d.autonomous = item_i.autonomous;
    cmd_d.id_ok      = item_i.lamp_id < LampLimit;
    cmd_d.fill_ok    = (item_i.lamp_id < LampLimit) && (item_i.range_end < LampLimit) &&
                       (item_i.lamp_id <= item_i.range_end);
    unique case (item_i.op)
      OP_WRITE:    cmd_d.kind = CMD_WRITE;
      OP_FILL:     cmd_d.kind = CMD_FILL;
      OP_MODE:     cmd_d.kind = CMD_MODE;
      OP_ATTR_REQ: cmd_d.kind = CMD_ATTR_REQ;
      OP_ATTR_RD:  cmd_d.kind = CMD_ATTR_RD;
      OP_COL_RD:   cmd_d.kind = CMD_COL_RD;
      default:     cmd_d.kind = CMD_NOP;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2) || hold_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign take        = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(accept) - 2'(take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

`default_nettype wire

### design/lad_back.sv
// ----------------------------------------------------------------------------
// Lamp array cache back end
// Executes commands on the pending and shown colour buffers and queues results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lad_back import lad_pkg::*; #(
  parameter int NUM_LAMPS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_ready_o,
  input  wire logic [31:0] dflt_colour_i,
  output logic             init_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output out_item_t        result_o
);

  localparam int IW = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
  localparam logic [IW-1:0] Last = IW'(NUM_LAMPS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_FILL  = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_READ  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] end_q, end_d;
  logic [31:0]   col_q, col_d;
  logic          cmt_q, cmt_d;
  logic          mode_q, mode_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic          init_q, init_d;
  logic          cp_vld_q, cp_vld_d;
  logic [IW-1:0] cp_addr_q, cp_addr_d;
  logic          rd_ok_q, rd_ok_d;

  logic          pw_we, sw_we;
  logic [IW-1:0] pw_addr, sw_addr, pr_addr, sr_addr;
  logic [31:0]   pw_data, sw_data, pend_rdata, shown_rdata, rd_colour;
  logic [IW-1:0] idx;

  out_item_t     res_q [2];
  out_item_t     res_d;
  logic          res_push, res_pop;
  logic          res_wr_q, res_rd_q;
  logic [1:0]    res_cnt_q;

  lad_ram #(.WIDTH(32), .DEPTH(NUM_LAMPS)) u_pending (
    .clk_i   (clk_i),
    .we_i    (pw_we),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .raddr_i (pr_addr),
    .rdata_o (pend_rdata)
  );

  lad_ram #(.WIDTH(32), .DEPTH(NUM_LAMPS)) u_shown (
    .clk_i   (clk_i),
    .we_i    (sw_we),
    .waddr_i (sw_addr),
    .wdata_i (sw_data),
    .raddr_i (sr_addr),
    .rdata_o (shown_rdata)
  );

  assign idx       = cmd_i.lamp_id[IW-1:0];
  assign rd_colour = mode_q ? dflt_colour_i : shown_rdata;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    col_d       = col_q;
    cmt_d       = cmt_q;
    mode_d      = mode_q;
    ptr_d       = ptr_q;
    init_d      = init_q;
    cp_vld_d    = 1'b0;
    cp_addr_d   = cp_addr_q;
    rd_ok_d     = rd_ok_q;
    pw_we       = 1'b0;
    pw_addr     = cnt_q;
    pw_data     = '0;
    sw_we       = cp_vld_q;
    sw_addr     = cp_addr_q;
    sw_data     = pend_rdata;
    pr_addr     = cnt_q;
    sr_addr     = idx;
    res_push    = 1'b0;
    res_d       = '0;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        pw_we   = 1'b1;
        sw_we   = 1'b1;
        sw_addr = cnt_q;
        sw_data = '0;
        if (cnt_q == Last) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && (res_cnt_q != 2'd2) && !cp_vld_q) begin
          cmd_ready_o = 1'b1;
          res_push    = (cmd_i.kind != CMD_COL_RD);
          unique case (cmd_i.kind)
            CMD_WRITE: begin
              pw_we   = cmd_i.wen && cmd_i.id_ok;
              pw_addr = idx;
              pw_data = cmd_i.colour;
              if (cmd_i.commit) begin
                state_d = ST_COPY;
                cnt_d   = '0;
              end
            end
            CMD_FILL: begin
              if (cmd_i.fill_ok) begin
                cnt_d   = idx;
                end_d   = cmd_i.range_end[IW-1:0];
                col_d   = cmd_i.colour;
                cmt_d   = cmd_i.commit;
                state_d = ST_FILL;
              end
            end
            CMD_MODE: begin
              mode_d = cmd_i.autonomous;
              if (cmd_i.autonomous) begin
                state_d = ST_CLEAR;
                cnt_d   = '0;
              end
            end
            CMD_ATTR_REQ: ptr_d = cmd_i.id_ok ? idx : '0;
            CMD_ATTR_RD: begin
              res_d.attr_index = 16'(ptr_q);
              ptr_d = (ptr_q == Last) ? '0 : ptr_q + IW'(1);
            end
            CMD_COL_RD: begin
              rd_ok_d = cmd_i.id_ok;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        pw_we   = 1'b1;
        pw_data = col_q;
        if (cnt_q == end_q) begin
          cnt_d   = '0;
          state_d = cmt_q ? ST_COPY : ST_IDLE;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      ST_COPY: begin
        cp_vld_d  = 1'b1;
        cp_addr_d = cnt_q;
        if (cnt_q == Last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      ST_READ: begin
        res_push = 1'b1;
        if (rd_ok_q) begin
          res_d.out_red   = rd_colour[7:0];
          res_d.out_green = rd_colour[15:8];
          res_d.out_blue  = rd_colour[23:16];
          res_d.out_gain  = rd_colour[31:24];
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign init_o   = init_q;
  assign empty_o  = (res_cnt_q == 2'd0);
  assign res_pop  = pop_i && !empty_o;
  assign result_o = res_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      mode_q    <= 1'b0;
      ptr_q     <= '0;
      init_q    <= 1'b1;
      cp_vld_q  <= 1'b0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      mode_q    <= mode_d;
      ptr_q     <= ptr_d;
      init_q    <= init_d;
      cp_vld_q  <= cp_vld_d;
      res_wr_q  <= res_push ? ~res_wr_q : res_wr_q;
      res_rd_q  <= res_pop ? ~res_rd_q : res_rd_q;
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    end_q     <= end_d;
    col_q     <= col_d;
    cmt_q     <= cmt_d;
    cp_addr_q <= cp_addr_d;
    rd_ok_q   <= rd_ok_d;
    if (res_push) begin
      res_q[res_wr_q] <= res_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (res_cnt_q != 2'd2 || res_pop))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_vld_q |-> (state_q == ST_IDLE || state_q == ST_COPY))
    else $error("copy write overlaps another buffer sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_IDLE))
    else $error("colour read did not return to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= Last)
    else $error("attribute pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (state_q == ST_CLEAR && !cmd_ready_o))
    else $error("command taken during reset clearing");

endmodule

`default_nettype wire

### design/lamp_array_double_buffered_cache.sv
// ----------------------------------------------------------------------------
// Lamp array double buffered colour cache
// A lamp write, range fill, mode change or attribute beat queues its result as it
// is accepted; a colour read queues its result from the ST_READ state.
// The back end takes one beat a cycle while idle, with room for a result and no copy
// write pending. A colour read holds it in ST_READ, a range fill in ST_FILL over the
// range, a commit in ST_COPY over all lamps, and autonomous mode entry in ST_CLEAR.
// ST_CLEAR clears both buffers; after reset it does so with full held high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lamp_array_double_buffered_cache import lad_pkg::*; #(
  parameter int NUM_LAMPS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire in_item_t              item_i,
  output logic                       full_o,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output out_item_t                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [31:0] dflt_q, dflt_d;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;
  logic        init;

  always_comb begin
    dflt_d = dflt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RED:   dflt_d[7:0]   = cfg_wdata_i;
        CFG_GREEN: dflt_d[15:8]  = cfg_wdata_i;
        CFG_BLUE:  dflt_d[23:16] = cfg_wdata_i;
        CFG_GAIN:  dflt_d[31:24] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= DEFAULT_COLOUR_RESET;
    end else begin
      dflt_q <= dflt_d;
    end
  end

  lad_front #(.NUM_LAMPS(NUM_LAMPS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .item_i      (item_i),
    .full_o      (full_o),
    .hold_i      (init),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  lad_back #(.NUM_LAMPS(NUM_LAMPS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_ready_o   (cmd_ready),
    .dflt_colour_i (dflt_q),
    .init_o        (init),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .result_o      (result_o)
  );

endmodule

`default_nettype wire
